>>> rtl/npcs_pkg.sv
// Shared types, constants and helpers for the nearest palette color search.
// No dependencies; imported by every module of the block.
package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int SIZE_W        = $clog2(PALETTE_DEPTH + 1);
  localparam int CHAN_W        = 8;
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = SQ_W + 2;
  localparam int IDX_W         = 8;

  localparam int CMD_Q_DEPTH   = 4;
  localparam int CMD_PTR_W     = $clog2(CMD_Q_DEPTH);
  localparam int CMD_CNT_W     = $clog2(CMD_Q_DEPTH + 1);
  localparam int RES_Q_DEPTH   = 2;
  localparam int RES_PTR_W     = $clog2(RES_Q_DEPTH);
  localparam int RES_CNT_W     = $clog2(RES_Q_DEPTH + 1);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_distance;
    logic              palette_empty;
  } res_t;

  // Squared absolute difference of two channel values.
  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

>>> rtl/npcs_front.sv
// Front end: accepts input transactions, decodes the command and buffers
// them in a short queue for the search engine. Depends on npcs_pkg.
module npcs_front
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] alpha,
  output logic              q_valid,
  output cmd_t              q_item,
  input  logic              q_pop
);

  cmd_t                 slots [CMD_Q_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;
  cmd_t                 item_in;

  assign full    = (count == CMD_CNT_W'(CMD_Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    item_in.op          = command ? OP_LOAD : OP_LOOKUP;
    item_in.entry_index = entry_index;
    item_in.red         = red;
    item_in.green       = green;
    item_in.blue        = blue;
    item_in.alpha       = alpha;
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/npcs_back.sv
// Back end: palette memory and the scan engine that finds the nearest entry.
// Pipeline: memory read, channel squares, sum and compare. Depends on npcs_pkg.
module npcs_back
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] palette_size,
  input  logic              q_valid,
  input  cmd_t              q_item,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [31:0]       mem [PALETTE_DEPTH];
  logic [SIZE_W-1:0] size_sat;
  logic              start_load;
  logic              start_lookup;
  logic              empty_hit;

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] n_last;
  logic              two_mode;
  cmd_t              query;
  logic              scan_last;

  // stage A: registered memory read
  logic [31:0]       rd_data;
  logic              a_valid;
  logic [ADDR_W-1:0] a_idx;
  logic              a_last;
  // stage B: squared channel differences
  logic [SQ_W-1:0]   sq [4];
  logic              b_valid;
  logic [ADDR_W-1:0] b_idx;
  logic              b_last;
  // stage C: running best
  logic [DIST_W-1:0] best_d;
  logic [ADDR_W-1:0] best_i;
  logic [DIST_W-1:0] cur_d;
  logic              take;
  logic [DIST_W-1:0] win_d;
  logic [ADDR_W-1:0] win_i;

  assign size_sat = (palette_size > SIZE_W'(PALETTE_DEPTH)) ? SIZE_W'(PALETTE_DEPTH)
                                                             : palette_size;

  assign start_load   = (state == ST_IDLE) && q_valid && (q_item.op == OP_LOAD);
  assign start_lookup = (state == ST_IDLE) && q_valid && (q_item.op == OP_LOOKUP)
                        && !res_full;
  assign empty_hit    = start_lookup && (size_sat == '0);
  assign q_pop        = start_load || start_lookup;
  assign scan_last    = (addr == n_last);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start_lookup && !empty_hit) state_next = ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_WAIT;
      ST_WAIT: if (b_valid && b_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // palette memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (start_load) begin
      mem[q_item.entry_index[ADDR_W-1:0]] <= {q_item.alpha, q_item.blue,
                                              q_item.green, q_item.red};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (start_lookup) begin
      query    <= q_item;
      n_last   <= ADDR_W'(size_sat - 1'b1);
      two_mode <= (size_sat == SIZE_W'(2));
    end
    if (state == ST_SCAN) begin
      a_idx  <= addr;
      a_last <= scan_last;
    end
    sq[0] <= chan_sq(rd_data[7:0],   query.red);
    sq[1] <= chan_sq(rd_data[15:8],  query.green);
    sq[2] <= chan_sq(rd_data[23:16], query.blue);
    sq[3] <= chan_sq(rd_data[31:24], query.alpha);
    b_idx  <= a_idx;
    b_last <= a_last;
    if (b_valid) begin
      best_d <= win_d;
      best_i <= win_i;
    end
  end

  always_comb begin
    cur_d = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]) + DIST_W'(sq[3]);
    // with exactly two entries a tie goes to entry 1
    take = (b_idx == '0) || (cur_d < best_d) || (two_mode && (cur_d == best_d));
    win_d = take ? cur_d : best_d;
    win_i = take ? b_idx : best_i;
  end

  always_comb begin
    res_push = empty_hit || (b_valid && b_last);
    if (empty_hit) begin
      res_data.nearest_index    = '0;
      res_data.nearest_distance = '0;
      res_data.palette_empty    = 1'b1;
    end else begin
      res_data.nearest_index    = IDX_W'(win_i);
      res_data.nearest_distance = win_d;
      res_data.palette_empty    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      addr    <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= (state == ST_SCAN);
      b_valid <= a_valid;
      if (start_lookup) addr <= '0;
      else if (state == ST_SCAN && !scan_last) addr <= addr + 1'b1;
    end
  end

endmodule

>>> rtl/npcs_result_q.sv
// Result queue between the scan engine and the output side.
// Holds finished lookups until popped. Depends on npcs_pkg.
module npcs_result_q
  import npcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t                 slots [RES_Q_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == RES_CNT_W'(RES_Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/nearest_palette_color_search.sv
// Nearest palette color search, top level. Load: the engine writes the palette entry.
// Lookup over n entries (n = palette_size, at most 256): the single palette read port
// scans one entry a cycle from queue head to result, and the engine takes the next
// lookup only after that result is pushed. Empty palette lookups push a result
// without a scan. A 4-deep command queue and a 2-deep result queue decouple the
// sides. rst (sync, high) empties both queues and clears palette_size; palette
// contents are not cleared.
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] alpha,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              empty,
  input  logic              pop,
  output logic [IDX_W-1:0]  nearest_index,
  output logic [DIST_W-1:0] nearest_distance,
  output logic              palette_empty
);

  logic [SIZE_W-1:0] palette_size;
  logic              q_valid;
  cmd_t              q_item;
  logic              q_pop;
  logic              res_full;
  logic              res_push;
  res_t              res_data;
  res_t              head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) palette_size <= '0;
    else if (cfg_valid) palette_size <= cfg_data;
  end

  npcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  npcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .palette_size (palette_size),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_data)
  );

  npcs_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign nearest_index    = head.nearest_index;
  assign nearest_distance = head.nearest_distance;
  assign palette_empty    = head.palette_empty;

endmodule
